>>> src/tspf_pkg.sv
package tspf_pkg;

  // memory geometry
  localparam int unsigned TILE_BYTES  = 32768;
  localparam int unsigned TILE_AW     = $clog2(TILE_BYTES);
  localparam int unsigned PAL_ENTRIES = 256;
  localparam int unsigned PAL_AW      = $clog2(PAL_ENTRIES);

  // command codes carried in tuser
  localparam logic [1:0] CMD_TILE_WR = 2'd0;
  localparam logic [1:0] CMD_PAL_WR  = 2'd1;
  localparam logic [1:0] CMD_FETCH   = 2'd2;

  // pixel status codes
  localparam logic [2:0] ST_VISIBLE     = 3'd0;
  localparam logic [2:0] ST_HIDDEN      = 3'd1;
  localparam logic [2:0] ST_UNSUPPORTED = 3'd2;
  localparam logic [2:0] ST_TRUNCATED   = 3'd3;
  localparam logic [2:0] ST_OUTSIDE     = 3'd4;
  localparam logic [2:0] ST_ABSENT      = 3'd5;

  // configuration register indexes
  localparam logic [2:0] CFG_ATTR_ZERO      = 3'd0;
  localparam logic [2:0] CFG_ATTR_ONE       = 3'd1;
  localparam logic [2:0] CFG_ATTR_TWO       = 3'd2;
  localparam logic [2:0] CFG_CONTROL_FLAGS  = 3'd3;
  localparam logic [2:0] CFG_OBJECT_PRESENT = 3'd4;
  localparam logic [2:0] CFG_LINEAR_MAPPING = 3'd5;

  typedef struct packed {
    logic [15:0] attr_zero;
    logic [15:0] attr_one;
    logic [15:0] attr_two;
    logic [2:0]  control_flags;
    logic        object_present;
    logic        linear_mapping;
  } cfg_regs_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [6:0]         width;
    logic [6:0]         height;
    logic [TILE_AW-1:0] byte_addr;
    logic               nib_hi;
    logic [3:0]         bank;
  } fetch_class_t;

  // object width from shape and size
  function automatic logic [6:0] obj_width(input logic [1:0] shape, input logic [1:0] size);
    logic [6:0] w;
    case ({shape, size})
      4'b00_00: w = 7'd8;
      4'b00_01: w = 7'd16;
      4'b00_10: w = 7'd32;
      4'b00_11: w = 7'd64;
      4'b01_00: w = 7'd16;
      4'b01_01: w = 7'd32;
      4'b01_10: w = 7'd32;
      4'b01_11: w = 7'd64;
      4'b10_00: w = 7'd8;
      4'b10_01: w = 7'd8;
      4'b10_10: w = 7'd16;
      4'b10_11: w = 7'd32;
      default:  w = 7'd0;
    endcase
    return w;
  endfunction

  // object height from shape and size
  function automatic logic [6:0] obj_height(input logic [1:0] shape, input logic [1:0] size);
    logic [6:0] h;
    case ({shape, size})
      4'b00_00: h = 7'd8;
      4'b00_01: h = 7'd16;
      4'b00_10: h = 7'd32;
      4'b00_11: h = 7'd64;
      4'b01_00: h = 7'd8;
      4'b01_01: h = 7'd8;
      4'b01_10: h = 7'd16;
      4'b01_11: h = 7'd32;
      4'b10_00: h = 7'd16;
      4'b10_01: h = 7'd32;
      4'b10_10: h = 7'd32;
      4'b10_11: h = 7'd64;
      default:  h = 7'd0;
    endcase
    return h;
  endfunction

  // 5-bit channel to 8 bits
  function automatic logic [7:0] expand5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

endpackage

>>> src/tspf_tile_mem.sv
module tspf_tile_mem import tspf_pkg::*; (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [TILE_AW-1:0] wr_addr,
  input  logic [7:0]         wr_data,
  input  logic               rd_en,
  input  logic [TILE_AW-1:0] rd_addr,
  output logic [7:0]         rd_data_r
);

  logic [7:0] mem [TILE_BYTES];

  // byte write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port, holds while idle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

>>> src/tspf_pal_mem.sv
module tspf_pal_mem import tspf_pkg::*; (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [PAL_AW-1:0] wr_addr,
  input  logic [14:0]       wr_data,
  input  logic              rd_en,
  input  logic [PAL_AW-1:0] rd_addr,
  output logic [14:0]       rd_data_r
);

  logic [14:0] mem [PAL_ENTRIES];

  // colour write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port, read-before-write on a shared edge
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

>>> src/tspf_classify.sv
module tspf_classify import tspf_pkg::*; (
  input  cfg_regs_t    cfg,
  input  logic [5:0]   pixel_x,
  input  logic [5:0]   pixel_y,
  output fetch_class_t cls
);

  logic [1:0]  shape;
  logic [1:0]  size;
  logic [9:0]  tile;
  logic [6:0]  w;
  logic [6:0]  h;
  logic [3:0]  w8;
  logic [2:0]  h8m1;
  logic [5:0]  stride;
  logic [10:0] span;
  logic [17:0] span_end;
  logic [8:0]  bank_end;
  logic        hidden;
  logic        unsupported;
  logic        truncated;
  logic        outside;
  logic [6:0]  sx_full;
  logic [6:0]  sy_full;
  logic [5:0]  sx;
  logic [5:0]  sy;
  logic [10:0] row_base;
  logic [15:0] byte_addr;

  assign shape = cfg.attr_zero[15:14];
  assign size  = cfg.attr_one[15:14];
  assign tile  = cfg.attr_two[9:0];
  assign w     = obj_width(shape, size);
  assign h     = obj_height(shape, size);
  assign w8    = w[6:3];
  assign h8m1  = 3'(h[6:3] - 4'd1);

  // tile row stride: width in tiles for 1d, fixed 32 for 2d
  assign stride = cfg.linear_mapping ? {2'b00, w8} : 6'd32;

  // end of the tile span and of the palette bank
  assign span     = 11'(tile) + 11'(h8m1) * 11'(stride) + 11'(w8);
  assign span_end = {2'b00, span, 5'b0};
  assign bank_end = {1'b0, cfg.attr_two[15:12], 4'b0} + 9'd16;

  assign hidden = !cfg.control_flags[0] || cfg.control_flags[2] ||
                  (cfg.attr_zero[9:8] == 2'b10);
  assign unsupported = (cfg.attr_zero[13:10] != 4'd0) || cfg.attr_zero[8] ||
                       (shape == 2'b11) || !cfg.control_flags[1];
  assign truncated = (span_end > 18'(TILE_BYTES)) || (bank_end > 9'(PAL_ENTRIES));
  assign outside   = ({1'b0, pixel_x} >= w) || ({1'b0, pixel_y} >= h);

  // flipped source coordinates
  assign sx_full = cfg.attr_one[12] ? (w - 7'd1 - {1'b0, pixel_x}) : {1'b0, pixel_x};
  assign sy_full = cfg.attr_one[13] ? (h - 7'd1 - {1'b0, pixel_y}) : {1'b0, pixel_y};
  assign sx      = sx_full[5:0];
  assign sy      = sy_full[5:0];

  // byte address: tile base, row within tile, pixel pair
  assign row_base  = 11'(tile) + 11'(sy[5:3]) * 11'(stride) + 11'(sx[5:3]);
  assign byte_addr = {row_base, sy[2:0], sx[2:1]};

  // status priority and size fields
  always_comb begin
    cls.width     = 7'd0;
    cls.height    = 7'd0;
    cls.byte_addr = byte_addr[TILE_AW-1:0];
    cls.nib_hi    = sx[0];
    cls.bank      = cfg.attr_two[15:12];
    if (!cfg.object_present) begin
      cls.status = ST_ABSENT;
    end else if (hidden) begin
      cls.status = ST_HIDDEN;
    end else if (unsupported) begin
      cls.status = ST_UNSUPPORTED;
    end else begin
      cls.width  = w;
      cls.height = h;
      if (truncated) begin
        cls.status = ST_TRUNCATED;
      end else if (outside) begin
        cls.status = ST_OUTSIDE;
      end else begin
        cls.status = ST_VISIBLE;
      end
    end
  end

endmodule

>>> src/tiled_sprite_pixel_fetch_unit.sv
// Object sprite pixel fetch, 4 bits per pixel.
// The input stream carries a command in in_tuser: tile byte write, palette
// colour write or pixel fetch. Writes fill the tile byte memory and the
// BGR555 palette memory and give no output transaction. A fetch gives one
// output transaction with a status in out_tuser and, in out_tdata, RGB888 and
// opacity when visible and the sprite size when truncated, outside or visible.
// Object attributes and control flags are written through the cfg port (always
// ready); write them only while no fetch is in flight, the block does not enforce it.
// A fetch passes the tile read stage, the palette read stage and the output
// register in that order; the tile read and the palette read each use a
// synchronous memory.
// Throughput: one transaction per cycle while the receiver does not stall; the two
// memory reads are pipelined behind each other, so back-to-back fetches are taken.
// When the receiver stalls, the output register holds its transaction, the
// two read stages fill up behind it and in_tready drops after that.
// Reset clears the configuration and all valid flags; memory contents are
// undefined until written.
module tiled_sprite_pixel_fetch_unit import tspf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // input transactions
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,  // address[14:0], write_data[30:15], pixel_x[36:31],
                                 // pixel_y[42:37], zero fill
  input  logic [1:0]  in_tuser,  // cmd[1:0]
  // result transactions
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata, // red[7:0], green[15:8], blue[23:16], opaque[24],
                                 // sprite_width[31:25], sprite_height[38:32], zero fill
  output logic [2:0]  out_tuser, // pixel_status[2:0]
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // input fields
  logic [1:0]   in_cmd;
  logic [14:0]  in_address;
  logic [15:0]  in_write_data;
  logic [5:0]   in_pixel_x;
  logic [5:0]   in_pixel_y;
  logic         in_fire;
  logic         fetch_fire;

  cfg_regs_t    cfg_r;
  fetch_class_t cls;

  // memory ports
  logic [16:0]        tile_wr_ext;
  logic               tile_wr_en;
  logic [7:0]         tile_rd_data;
  logic [8:0]         pal_wr_ext;
  logic               pal_wr_en;
  logic [14:0]        pal_rd_data;
  logic               pal_rd_en;
  logic [3:0]         nibble;
  logic [7:0]         pal_addr;

  // tile read stage
  logic         s1_v_r;
  logic [2:0]   s1_status_r;
  logic [6:0]   s1_w_r;
  logic [6:0]   s1_h_r;
  logic         s1_nib_hi_r;
  logic [3:0]   s1_bank_r;
  logic         s1_move;

  // palette read stage
  logic         s2_v_r;
  logic [2:0]   s2_status_r;
  logic [6:0]   s2_w_r;
  logic [6:0]   s2_h_r;
  logic         s2_opaque_r;
  logic         s2_move;

  // output register
  logic         out_v_r;
  logic [2:0]   out_status_r;
  logic [7:0]   out_red_r;
  logic [7:0]   out_green_r;
  logic [7:0]   out_blue_r;
  logic         out_opaque_r;
  logic [6:0]   out_w_r;
  logic [6:0]   out_h_r;
  logic         s2_visible;

  assign in_cmd        = in_tuser;
  assign in_address    = in_tdata[14:0];
  assign in_write_data = in_tdata[30:15];
  assign in_pixel_x    = in_tdata[36:31];
  assign in_pixel_y    = in_tdata[42:37];

  // stage advance
  assign s2_move    = s2_v_r && (!out_v_r || out_tready);
  assign s1_move    = s1_v_r && (!s2_v_r || s2_move);
  assign in_tready  = !s1_v_r || s1_move;
  assign in_fire    = in_tvalid && in_tready;
  assign fetch_fire = in_fire && (in_cmd == CMD_FETCH);

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ATTR_ZERO:      cfg_r.attr_zero      <= cfg_data;
        CFG_ATTR_ONE:       cfg_r.attr_one       <= cfg_data;
        CFG_ATTR_TWO:       cfg_r.attr_two       <= cfg_data;
        CFG_CONTROL_FLAGS:  cfg_r.control_flags  <= cfg_data[2:0];
        CFG_OBJECT_PRESENT: cfg_r.object_present <= cfg_data[0];
        CFG_LINEAR_MAPPING: cfg_r.linear_mapping <= cfg_data[0];
        default: ;
      endcase
    end
  end

  tspf_classify u_classify (
    .cfg     (cfg_r),
    .pixel_x (in_pixel_x),
    .pixel_y (in_pixel_y),
    .cls     (cls)
  );

  // write decode with range checks
  assign tile_wr_ext = 17'(in_address);
  assign tile_wr_en  = in_fire && (in_cmd == CMD_TILE_WR) && (tile_wr_ext < 17'(TILE_BYTES));
  assign pal_wr_ext  = {1'b0, in_address[7:0]};
  assign pal_wr_en   = in_fire && (in_cmd == CMD_PAL_WR) && (pal_wr_ext < 9'(PAL_ENTRIES));

  tspf_tile_mem u_tile_mem (
    .clk       (clk),
    .wr_en     (tile_wr_en),
    .wr_addr   (tile_wr_ext[TILE_AW-1:0]),
    .wr_data   (in_write_data[7:0]),
    .rd_en     (fetch_fire && (cls.status == ST_VISIBLE)),
    .rd_addr   (cls.byte_addr),
    .rd_data_r (tile_rd_data)
  );

  // tile read stage context
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= fetch_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fetch_fire) begin
      s1_status_r <= cls.status;
      s1_w_r      <= cls.width;
      s1_h_r      <= cls.height;
      s1_nib_hi_r <= cls.nib_hi;
      s1_bank_r   <= cls.bank;
    end
  end

  // palette index from the pixel nibble
  assign nibble    = s1_nib_hi_r ? tile_rd_data[7:4] : tile_rd_data[3:0];
  assign pal_addr  = {s1_bank_r, 4'b0} + {4'b0, nibble};
  assign pal_rd_en = s1_move && (s1_status_r == ST_VISIBLE);

  tspf_pal_mem u_pal_mem (
    .clk       (clk),
    .wr_en     (pal_wr_en),
    .wr_addr   (pal_wr_ext[PAL_AW-1:0]),
    .wr_data   (in_write_data[14:0]),
    .rd_en     (pal_rd_en),
    .rd_addr   (pal_addr[PAL_AW-1:0]),
    .rd_data_r (pal_rd_data)
  );

  // palette read stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (!s2_v_r || s2_move) begin
      s2_v_r <= s1_move;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_status_r <= s1_status_r;
      s2_w_r      <= s1_w_r;
      s2_h_r      <= s1_h_r;
      s2_opaque_r <= (s1_status_r == ST_VISIBLE) && (nibble != 4'd0);
    end
  end

  // output register
  assign s2_visible = (s2_status_r == ST_VISIBLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (!out_v_r || out_tready) begin
      out_v_r <= s2_move;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_move) begin
      out_status_r <= s2_status_r;
      out_red_r    <= s2_visible ? expand5(pal_rd_data[4:0])   : 8'd0;
      out_green_r  <= s2_visible ? expand5(pal_rd_data[9:5])   : 8'd0;
      out_blue_r   <= s2_visible ? expand5(pal_rd_data[14:10]) : 8'd0;
      out_opaque_r <= s2_opaque_r;
      out_w_r      <= s2_w_r;
      out_h_r      <= s2_h_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {1'b0, out_h_r, out_w_r, out_opaque_r,
                       out_blue_r, out_green_r, out_red_r};

  // a fetch always lands in the tile read stage
  a_fetch_enters: assert property (@(posedge clk) disable iff (!rst_n)
    fetch_fire |=> s1_v_r)
    else $error("fetch transaction lost at tile read stage");

  // a blocked tile read stage keeps its context
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !s1_move |=> s1_v_r && $stable(s1_status_r) && $stable(s1_nib_hi_r))
    else $error("tile read stage changed while blocked");

  // colour fields only on visible pixels
  a_colour_gated: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && (out_status_r != ST_VISIBLE) |->
      (out_red_r == 8'd0) && (out_green_r == 8'd0) && (out_blue_r == 8'd0) && !out_opaque_r)
    else $error("colour on a pixel that is not visible");

  // no size on absent, hidden or unsupported objects
  a_size_gated: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && ((out_status_r == ST_ABSENT) || (out_status_r == ST_HIDDEN) ||
                (out_status_r == ST_UNSUPPORTED)) |-> (out_w_r == 7'd0) && (out_h_r == 7'd0))
    else $error("sprite size reported without a classified object");

endmodule
